// ===== src/lbki_pkg.sv =====
// ============================================================================
// lbki_pkg
// Shared types and constants of the line break key frame indexer.
// ============================================================================
package lbki_pkg;

    // Width of the row, offset and line count fields on the result channel.
    localparam int FIELD_W = 48;

    // Encoding modes. Mode three is not a defined code and behaves as single-byte.
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_UTF16LE = 2'd1;
    localparam logic [1:0] MODE_UTF16BE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = 1'd1;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] FRAME_INTERVAL_RESET = 16'd1024;

    // Break characters, compared as 16-bit units.
    localparam logic [15:0] UNIT_LF = 16'h000A;
    localparam logic [15:0] UNIT_CR = 16'h000D;

    // Result kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // Result queue geometry.
    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 4;
    localparam int PTR_W       = 2;
    localparam int FILL_W      = 3;

    typedef struct packed {
        logic               result_kind;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] byte_offset;
        logic [FIELD_W-1:0] line_count;
        logic               too_long;
        logic               run_end;
    } res_t;

    // Results produced by one item, packed from slot zero upward.
    typedef struct packed {
        logic [1:0]   cnt;
        res_t [2:0]   rec;
    } push_t;

    typedef struct packed {
        logic              room;
        logic [FILL_W-1:0] fill;
    } fifo_stat_t;

endpackage

// ===== src/lbki_if.sv =====
// ============================================================================
// lbki_if
// Valid/ready channels of the indexer: byte items in, result items out.
// ============================================================================
interface lbki_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_byte, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input last_byte, output ready);
endinterface

interface lbki_out_if;
    import lbki_pkg::*;

    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] byte_offset;
    logic [FIELD_W-1:0] line_count;
    logic               too_long;
    logic               run_end;

    modport source (output valid, output result_kind, output row, output byte_offset,
                    output line_count, output too_long, output run_end, input ready);
    modport sink (input valid, input result_kind, input row, input byte_offset,
                  input line_count, input too_long, input run_end, output ready);
endinterface

// ===== src/lbki_scan.sv =====
// ============================================================================
// lbki_scan
// Input register, document state and the per-item update that produces up
// to three results.
// ============================================================================
module lbki_scan #(
    parameter int COUNT_WIDTH = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lbki_in_if.sink                bytes,
    input  logic [1:0]             encoding_mode,
    input  logic [15:0]            frame_interval,
    input  lbki_pkg::fifo_stat_t   fifo_stat,
    output lbki_pkg::push_t        push
);
    import lbki_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // Input register
    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_bvalid_reg;
    logic       item_last_reg;

    // Document state
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] bc_reg, bc_next;
    logic [15:0]            btf_reg, btf_next;
    logic [7:0]             held_reg, held_next;
    logic                   half_reg, half_next;
    logic                   crp_reg, crp_next;
    logic                   lub_reg, lub_next;
    logic                   started_reg, started_next;
    logic                   sat_reg, sat_next;

    logic                   advance;
    logic [15:0]            btf0, btf_a, btf_c, btf_b;
    logic                   pos_at_max, bc_at_max;
    logic [COUNT_WIDTH-1:0] pos1, unit_start, bc_c, end_ofs, lines;
    logic                   sat1, sat_c, sat_f;
    logic                   wide, complete, half1, cnt, cr_x, lub_x;
    logic [7:0]             held1;
    logic [15:0]            unit;
    logic                   is_lf, is_cr;
    logic                   due_a, due_b, due_e;
    res_t                   cand [4];
    logic [3:0]             cand_v;
    logic [1:0]             slot;

    assign advance     = item_valid_reg && fifo_stat.room;
    assign bytes.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (bytes.valid && bytes.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            item_byte_reg   <= bytes.data_byte;
            item_bvalid_reg <= bytes.byte_valid;
            item_last_reg   <= bytes.last_byte;
        end
    end

    // Byte path: position, unit assembly and break counting.
    always_comb
    begin
        btf0       = started_reg ? btf_reg : frame_interval;
        pos_at_max = (pos_reg == CMAX);
        sat1       = sat_reg | (item_bvalid_reg & pos_at_max);
        pos1       = (item_bvalid_reg && !pos_at_max) ? pos_reg + 1'b1 : pos_reg;

        wide     = (encoding_mode == MODE_UTF16LE) || (encoding_mode == MODE_UTF16BE);
        complete = item_bvalid_reg && !(wide && !half_reg);
        half1    = item_bvalid_reg ? (wide && !half_reg) : half_reg;
        held1    = (item_bvalid_reg && wide && !half_reg) ? item_byte_reg : held_reg;

        if (!wide)
        begin
            unit       = {8'h00, item_byte_reg};
            unit_start = pos_reg;
        end
        else
        begin
            unit       = (encoding_mode == MODE_UTF16LE) ? {item_byte_reg, held_reg}
                                                         : {held_reg, item_byte_reg};
            unit_start = (pos_reg != '0) ? pos_reg - 1'b1 : pos_reg;
        end
        is_lf = (unit == UNIT_LF);
        is_cr = (unit == UNIT_CR);

        // A key frame held back by a CR is settled by the unit that follows.
        due_a = complete && crp_reg && (btf0 == 16'd0) && (bc_reg != '0);
        btf_a = due_a ? frame_interval : btf0;

        // A CR LF pair was already counted at the CR.
        cnt       = complete && (is_lf || is_cr) && !(crp_reg && is_lf);
        bc_at_max = (bc_reg == CMAX);
        if (cnt && !bc_at_max)
        begin
            bc_c  = bc_reg + 1'b1;
            btf_c = (btf_a <= 16'd1) ? 16'd0 : btf_a - 16'd1;
        end
        else
        begin
            bc_c  = bc_reg;
            btf_c = btf_a;
        end
        sat_c = sat1 | (cnt && bc_at_max);

        due_b = complete && is_lf && !crp_reg && (btf_c == 16'd0) && (bc_c != '0);
        btf_b = due_b ? frame_interval : btf_c;

        cr_x  = complete ? (cnt && is_cr) : crp_reg;
        lub_x = complete ? (is_lf || is_cr) : lub_reg;

        // End of document: a trailing half unit does not count toward the offset of the key frame after a final CR.
        end_ofs = (half1 && pos1 != '0) ? pos1 - 1'b1 : pos1;
        due_e   = item_last_reg && cr_x && (btf_b == 16'd0) && (bc_c != '0);
        lines   = (lub_x || bc_c == CMAX) ? bc_c : bc_c + 1'b1;
        sat_f   = sat_c | (item_last_reg && !lub_x && bc_c == CMAX);
    end

    // Candidate results in emission order, then packed into slots.
    always_comb
    begin
        cand_v[0]            = advance && !started_reg;
        cand[0].result_kind  = KIND_FRAME;
        cand[0].row          = '0;
        cand[0].byte_offset  = '0;
        cand[0].line_count   = '0;
        cand[0].too_long     = sat_reg;
        cand[0].run_end      = 1'b0;

        cand_v[1]            = advance && (due_a || due_b);
        cand[1].result_kind  = KIND_FRAME;
        cand[1].row          = due_a ? FIELD_W'(bc_reg) : FIELD_W'(bc_c);
        cand[1].byte_offset  = (due_a && !is_lf) ? FIELD_W'(unit_start) : FIELD_W'(pos1);
        cand[1].line_count   = '0;
        cand[1].too_long     = due_a ? sat1 : sat_c;
        cand[1].run_end      = 1'b0;

        cand_v[2]            = advance && due_e;
        cand[2].result_kind  = KIND_FRAME;
        cand[2].row          = FIELD_W'(bc_c);
        cand[2].byte_offset  = FIELD_W'(end_ofs);
        cand[2].line_count   = '0;
        cand[2].too_long     = sat_c;
        cand[2].run_end      = 1'b0;

        cand_v[3]            = advance && item_last_reg;
        cand[3].result_kind  = KIND_COUNT;
        cand[3].row          = FIELD_W'(bc_c);
        cand[3].byte_offset  = FIELD_W'(pos1);
        cand[3].line_count   = FIELD_W'(lines);
        cand[3].too_long     = sat_f;
        cand[3].run_end      = 1'b0;

        push.rec = '0;
        slot     = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && slot != 2'd3)
            begin
                push.rec[slot] = cand[i];
                slot           = slot + 2'd1;
            end
        end
        if (slot != 2'd0)
        begin
            push.rec[slot - 2'd1].run_end = 1'b1;
        end
        push.cnt = slot;
    end

    // Next document state; the end of a document returns everything to reset.
    always_comb
    begin
        pos_next     = pos_reg;
        bc_next      = bc_reg;
        btf_next     = btf_reg;
        held_next    = held_reg;
        half_next    = half_reg;
        crp_next     = crp_reg;
        lub_next     = lub_reg;
        started_next = started_reg;
        sat_next     = sat_reg;
        if (advance)
        begin
            if (item_last_reg)
            begin
                pos_next     = '0;
                bc_next      = '0;
                btf_next     = '0;
                held_next    = '0;
                half_next    = 1'b0;
                crp_next     = 1'b0;
                lub_next     = 1'b0;
                started_next = 1'b0;
                sat_next     = 1'b0;
            end
            else
            begin
                pos_next     = pos1;
                bc_next      = bc_c;
                btf_next     = btf_b;
                held_next    = held1;
                half_next    = half1;
                crp_next     = cr_x;
                lub_next     = lub_x;
                started_next = 1'b1;
                sat_next     = sat_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            bc_reg      <= '0;
            btf_reg     <= '0;
            held_reg    <= '0;
            half_reg    <= 1'b0;
            crp_reg     <= 1'b0;
            lub_reg     <= 1'b0;
            started_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            bc_reg      <= bc_next;
            btf_reg     <= btf_next;
            held_reg    <= held_next;
            half_reg    <= half_next;
            crp_reg     <= crp_next;
            lub_reg     <= lub_next;
            started_reg <= started_next;
            sat_reg     <= sat_next;
        end
    end

endmodule

// ===== src/lbki_rfifo.sv =====
// ============================================================================
// lbki_rfifo
// Result queue: takes up to three results per cycle, hands out one per
// transaction.
// ============================================================================
module lbki_rfifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbki_pkg::push_t      push,
    lbki_out_if.source           results,
    output lbki_pkg::fifo_stat_t stat
);
    import lbki_pkg::*;

    res_t              mem [RES_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              pop;
    res_t              head;

    assign pop  = results.valid && results.ready;
    assign head = mem[rd_ptr_reg];

    assign results.valid       = (fill_reg != '0);
    assign results.result_kind = head.result_kind;
    assign results.row         = head.row;
    assign results.byte_offset = head.byte_offset;
    assign results.line_count  = head.line_count;
    assign results.too_long    = head.too_long;
    assign results.run_end     = head.run_end;

    // Room is judged on the current fill so that a full item always fits.
    assign stat.room = (fill_reg <= FILL_W'(RES_DEPTH - MAX_RESULTS));
    assign stat.fill = fill_reg;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign fill_next   = fill_reg + FILL_W'(push.cnt) - FILL_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push.cnt)
            begin
                mem[wr_ptr_reg + PTR_W'(k)] <= push.rec[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== src/line_break_key_frame_indexer.sv =====
// ============================================================================
// line_break_key_frame_indexer
// Counts LF, CR and CR LF breaks in a byte stream and reports key frames and
// the final line count.
// ============================================================================
// The block takes one byte item per clock while the result queue has room. An
// accepted item waits in the input register, where the document state is
// updated and up to three results (start key frame, break key frame, key frame
// after a final CR, line count) are written at once into a four-entry result
// queue, which offers them at one per transaction. The input keeps taking
// one item per cycle as long as the queue holds at most one result, which it
// does whenever results are taken as fast as they appear; only an item that
// makes several results, or a stalled result side, holds the input back.
// Configuration writes take effect on the next cycle and must only be made
// between documents. There is no start-up clearing pass.
module line_break_key_frame_indexer #(
    parameter int COUNT_WIDTH = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lbki_in_if.sink                           bytes,
    lbki_out_if.source                        results,
    input  logic                              cfg_we,
    input  logic [lbki_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbki_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lbki_pkg::*;

    logic [1:0]  encoding_mode_reg;
    logic [15:0] frame_interval_reg;
    push_t       push;
    fifo_stat_t  fifo_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_mode_reg  <= MODE_BYTE;
            frame_interval_reg <= FRAME_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENCODING_MODE:  encoding_mode_reg  <= cfg_data[1:0];
                REG_FRAME_INTERVAL: frame_interval_reg <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    lbki_scan #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .bytes          (bytes),
        .encoding_mode  (encoding_mode_reg),
        .frame_interval (frame_interval_reg),
        .fifo_stat      (fifo_stat),
        .push           (push)
    );

    lbki_rfifo u_rfifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .results (results),
        .stat    (fifo_stat)
    );

    // Results are only written when the queue has room for a whole item.
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> fifo_stat.room)
        else $error("result push without room in the queue");

    // The last result written for an item carries the run end mark.
    a_run_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> push.rec[push.cnt - 2'd1].run_end)
        else $error("last result of an item lacks run_end");

    // A line count always closes the results of its item.
    a_count_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.result_kind == KIND_COUNT) |-> results.run_end)
        else $error("line count result without run_end");

    // The queue never holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.fill <= FILL_W'(RES_DEPTH))
        else $error("result queue overfilled");

endmodule

// ===== tb/line_index_checker.sv =====
// ============================================================================
// line_index_checker
// Watches the byte and result channels of the line break key frame indexer,
// keeps its own copy of the document state and registers, predicts the key
// frames and line counts of each byte transaction and compares every result
// transaction, field by field, with the oldest prediction.
// ============================================================================
module line_index_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    lbki_in_if                                bytes_ch,
    lbki_out_if                               results_ch,
    input  logic                              cfg_we,
    input  logic [lbki_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbki_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lbki_pkg::*;

    localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

    // Register copies.
    logic [1:0]         enc_mode;
    logic [15:0]        frame_gap;

    // Document state.
    logic [FIELD_W-1:0] doc_pos;
    logic [FIELD_W-1:0] doc_breaks;
    logic [15:0]        breaks_left;
    logic [7:0]         held_byte;
    logic               half_held;
    logic               cr_waiting;
    logic               ended_on_break;
    logic               doc_open;
    logic               doc_saturated;

    res_t               batch[$];
    res_t               due_records[$];
    int                 errors;

    function automatic void clear_document();
        doc_pos        = '0;
        doc_breaks     = '0;
        breaks_left    = '0;
        held_byte      = '0;
        half_held      = 1'b0;
        cr_waiting     = 1'b0;
        ended_on_break = 1'b0;
        doc_open       = 1'b0;
        doc_saturated  = 1'b0;
    endfunction

    function automatic void push_record(logic kind, logic [FIELD_W-1:0] row,
                                        logic [FIELD_W-1:0] ofs,
                                        logic [FIELD_W-1:0] lines);
        res_t r;
        if (batch.size() < MAX_RESULTS)
        begin
            r.result_kind = kind;
            r.row         = row;
            r.byte_offset = ofs;
            r.line_count  = lines;
            r.too_long    = doc_saturated;
            r.run_end     = 1'b0;
            batch = {batch, r};
        end
    endfunction

    function automatic void count_break();
        if (doc_breaks == COUNT_MAX)
        begin
            doc_saturated = 1'b1;
        end
        else
        begin
            doc_breaks  = doc_breaks + 1'b1;
            breaks_left = (breaks_left <= 16'd1) ? 16'd0 : breaks_left - 16'd1;
        end
    endfunction

    function automatic void frame_if_due_at(logic [FIELD_W-1:0] ofs);
        if (breaks_left == 16'd0 && doc_breaks != '0)
        begin
            push_record(KIND_FRAME, doc_breaks, ofs, '0);
            breaks_left = frame_gap;
        end
    endfunction

    // Advances the document by one byte transaction and queues its results.
    function automatic void index_byte(logic [7:0] data, logic has_byte, logic closes);
        logic               wide;
        logic               complete;
        logic               handled;
        logic [15:0]        unit;
        logic [FIELD_W-1:0] prior;
        logic [FIELD_W-1:0] unit_start;
        logic [FIELD_W-1:0] end_pos;
        logic [FIELD_W-1:0] lines;
        batch.delete();
        wide = (enc_mode == MODE_UTF16LE) || (enc_mode == MODE_UTF16BE);
        if (!doc_open)
        begin
            doc_open    = 1'b1;
            breaks_left = frame_gap;
            push_record(KIND_FRAME, '0, '0, '0);
        end
        if (has_byte)
        begin
            prior      = doc_pos;
            complete   = 1'b1;
            unit       = {8'h00, data};
            unit_start = prior;
            if (doc_pos == COUNT_MAX)
                doc_saturated = 1'b1;
            else
                doc_pos = doc_pos + 1'b1;
            if (wide)
            begin
                if (!half_held)
                begin
                    held_byte = data;
                    half_held = 1'b1;
                    complete  = 1'b0;
                end
                else
                begin
                    unit = (enc_mode == MODE_UTF16LE) ? {data, held_byte}
                                                       : {held_byte, data};
                    half_held  = 1'b0;
                    unit_start = (prior != '0) ? prior - 1'b1 : '0;
                end
            end
            else
            begin
                // A half unit left from a wide mode is dropped here.
                half_held = 1'b0;
            end
            if (complete)
            begin
                handled = 1'b0;
                if (cr_waiting)
                begin
                    cr_waiting = 1'b0;
                    if (unit == UNIT_LF)
                    begin
                        frame_if_due_at(doc_pos);
                        handled = 1'b1;
                    end
                    else
                    begin
                        frame_if_due_at(unit_start);
                    end
                end
                if (!handled)
                begin
                    if (unit == UNIT_LF)
                    begin
                        count_break();
                        frame_if_due_at(doc_pos);
                    end
                    else if (unit == UNIT_CR)
                    begin
                        count_break();
                        cr_waiting = 1'b1;
                    end
                end
                ended_on_break = (unit == UNIT_LF) || (unit == UNIT_CR);
            end
        end
        if (closes)
        begin
            if (cr_waiting)
            begin
                // The frame after a final CR sits at the end of the last whole unit.
                end_pos = doc_pos;
                if (half_held && end_pos != '0)
                    end_pos = end_pos - 1'b1;
                cr_waiting = 1'b0;
                frame_if_due_at(end_pos);
            end
            if (ended_on_break)
            begin
                lines = doc_breaks;
            end
            else if (doc_breaks == COUNT_MAX)
            begin
                doc_saturated = 1'b1;
                lines = doc_breaks;
            end
            else
            begin
                lines = doc_breaks + 1'b1;
            end
            push_record(KIND_COUNT, doc_breaks, doc_pos, lines);
            clear_document();
        end
        if (batch.size() > 0)
            batch[batch.size()-1].run_end = 1'b1;
        due_records = {due_records, batch};
    endfunction

    function automatic int field_differs(string name, logic [FIELD_W-1:0] want,
                                         logic [FIELD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic void check_result();
        res_t want;
        int   bad;
        if (due_records.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d row %0d",
                     $time, results_ch.result_kind, results_ch.row);
            errors++;
            return;
        end
        want = due_records.pop_front();
        bad  = 0;
        bad += field_differs("result_kind", FIELD_W'(want.result_kind),
                             FIELD_W'(results_ch.result_kind));
        bad += field_differs("row", want.row, results_ch.row);
        bad += field_differs("byte_offset", want.byte_offset, results_ch.byte_offset);
        bad += field_differs("line_count", want.line_count, results_ch.line_count);
        bad += field_differs("too_long", FIELD_W'(want.too_long),
                             FIELD_W'(results_ch.too_long));
        bad += field_differs("run_end", FIELD_W'(want.run_end),
                             FIELD_W'(results_ch.run_end));
        if (bad != 0)
            errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_mode  = MODE_BYTE;
            frame_gap = FRAME_INTERVAL_RESET;
            clear_document();
            due_records.delete();
            errors = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_ENCODING_MODE)
                    enc_mode = cfg_data[1:0];
                else if (cfg_index == REG_FRAME_INTERVAL)
                    frame_gap = cfg_data[15:0];
            end
            if (bytes_ch.valid && bytes_ch.ready)
                index_byte(bytes_ch.data_byte, bytes_ch.byte_valid, bytes_ch.last_byte);
            if (results_ch.valid && results_ch.ready)
                check_result();
            fail_count  <= errors;
            outstanding <= due_records.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ============================================================================
// tb
// Stimulus for the line break key frame indexer: directed documents over every
// encoding mode and corner of the break rules, then random documents under
// changing register settings, with bursty input and a stalling result side.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lbki_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int ITEM_TARGET   = 470;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_request = 1'b0;
    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;
    int                    items_sent = 0;
    int                    burst_left = 0;
    logic [1:0]            cur_mode = MODE_BYTE;

    lbki_in_if  bytes_ch();
    lbki_out_if results_ch();

    line_break_key_frame_indexer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_index_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes_ch    (bytes_ch),
        .results_ch  (results_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: the stall style is redrawn at random; on request it
    // holds off for a long stretch so the result queue fills.
    initial
    begin
        int   style;
        int   style_left;
        logic hold_done;
        style = 0;
        style_left = 0;
        hold_done = 1'b0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0: results_ch.ready <= 1'b1;
                    1: results_ch.ready <= 1'($urandom_range(0, 1));
                    2: results_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: results_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one byte transaction, in bursts with random gaps between them.
    task automatic send_item(input logic [7:0] data, input logic has_byte,
                             input logic closes);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                bytes_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        bytes_ch.valid      <= 1'b1;
        bytes_ch.data_byte  <= data;
        bytes_ch.byte_valid <= has_byte;
        bytes_ch.last_byte  <= closes;
        @(posedge clk);
        while (!bytes_ch.ready) @(posedge clk);
        if (has_byte || closes)
            items_sent++;
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic drain_results();
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic program_regs(input logic [1:0] mode, input logic [15:0] interval);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENCODING_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_index <= REG_FRAME_INTERVAL;
        cfg_data  <= interval;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic send_random_document(input logic [1:0] mode);
        logic [7:0]  doc[$];
        logic [15:0] unit;
        logic        wide;
        int          units;
        int          closing;
        int          idx;
        wide = (mode == MODE_UTF16LE) || (mode == MODE_UTF16BE);
        units = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
        for (idx = 0; idx < units; idx++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: unit = UNIT_LF;
                3, 4, 5: unit = UNIT_CR;
                // Break bytes in the wrong half of a wide unit.
                6: unit = $urandom_range(0, 1) ? {UNIT_LF[7:0], 8'h00}
                                               : {UNIT_CR[7:0], 8'h00};
                default: unit = 16'($urandom_range(0, 16'hFFFF));
            endcase
            if (!wide)
            begin
                doc = {doc, unit[7:0]};
            end
            else if (mode == MODE_UTF16LE)
            begin
                doc = {doc, unit[7:0], unit[15:8]};
            end
            else
            begin
                doc = {doc, unit[15:8], unit[7:0]};
            end
        end
        if (wide && $urandom_range(0, 3) == 0)
            doc = {doc, 8'($urandom_range(0, 255))};
        // Either the final byte carries the end mark or a byteless item closes.
        closing = (doc.size() == 0) ? 0 : $urandom_range(0, 2);
        for (idx = 0; idx < doc.size(); idx++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(doc[idx], 1'b1, (closing != 0) && (idx == doc.size() - 1));
        end
        if (closing == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int          doc_idx;
        logic [15:0] interval;
        bytes_ch.valid      = 1'b0;
        bytes_ch.data_byte  = 8'h00;
        bytes_ch.byte_valid = 1'b0;
        bytes_ch.last_byte  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ENCODING_MODE;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty document under the reset settings.
        send_item(8'h00, 1'b0, 1'b1);

        // Single-byte mode, a frame at every break: idle items, LF, lone CR,
        // CR LF, and a CR that ends the document.
        drain_results();
        program_regs(MODE_BYTE, 16'd1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(UNIT_LF[7:0], 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b0);
        send_item(UNIT_LF[7:0], 1'b1, 1'b0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b1);

        // Little endian with interval zero, CR LF units, a pending CR and a
        // trailing odd byte at the end.
        drain_results();
        program_regs(MODE_UTF16LE, 16'd0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(UNIT_LF[7:0], 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(UNIT_LF[7:0], 1'b1, 1'b1);

        // Big endian CR, then a switch to the reserved mode while a half unit
        // is held: the half is dropped and the LF pairs with the CR.
        drain_results();
        program_regs(MODE_UTF16BE, 16'hFFFF);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(UNIT_CR[7:0], 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        drain_results();
        program_regs(MODE_RESERVED, 16'hFFFF);
        send_item(UNIT_LF[7:0], 1'b1, 1'b0);
        send_item(8'h42, 1'b1, 1'b1);

        doc_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (doc_idx == 4)
            begin
                // Long result stall while every LF makes a key frame.
                drain_results();
                program_regs(MODE_BYTE, 16'd1);
                hold_request = 1'b1;
                repeat (40) send_item(UNIT_LF[7:0], 1'b1, 1'b0);
                send_item(8'h41, 1'b1, 1'b1);
            end
            if (doc_idx % 3 == 0)
            begin
                drain_results();
                case ($urandom_range(0, 9))
                    0: interval = 16'd0;
                    1: interval = 16'd1;
                    2: interval = 16'hFFFF;
                    3: interval = FRAME_INTERVAL_RESET;
                    default: interval = 16'($urandom_range(1, 4));
                endcase
                program_regs(2'($urandom_range(0, 3)), interval);
            end
            send_random_document(cur_mode);
            doc_idx++;
        end

        drain_results();
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lbki_pkg.sv
src/lbki_if.sv
src/lbki_scan.sv
src/lbki_rfifo.sv
src/line_break_key_frame_indexer.sv
tb/line_index_checker.sv
tb/tb.sv
